FILE: rtl/core/f2h_pkg.sv
`default_nettype none
package f2h_pkg;

  typedef struct packed {
    logic        command;
    logic [63:0] source_bits;
    logic [2:0]  rounding_mode;
  } f2h_in_t;

  typedef struct packed {
    logic [15:0] half_bits;
    logic [4:0]  exception_flags;
  } f2h_out_t;

  typedef enum logic [2:0] {
    RM_RNE = 3'd0,
    RM_RTZ = 3'd1,
    RM_RDN = 3'd2,
    RM_RUP = 3'd3,
    RM_RMM = 3'd4
  } f2h_rm_e;

  typedef enum logic [1:0] {
    CL_NAN  = 2'd0,
    CL_INF  = 2'd1,
    CL_ZERO = 2'd2,
    CL_FIN  = 2'd3
  } f2h_class_e;

  localparam logic [4:0] FLAG_NV = 5'b10000;
  localparam logic [4:0] FLAG_OF = 5'b00100;
  localparam logic [4:0] FLAG_UF = 5'b00010;
  localparam logic [4:0] FLAG_NX = 5'b00001;

  // Classified word: the significand is not yet normalized; lz counts its
  // leading zeros so the back end can align it.
  typedef struct packed {
    f2h_class_e  cls;
    logic        sign;
    logic        snan;
    f2h_rm_e     rm;
    logic [12:0] exp_b;   // signed unbiased exponent of bit 63 of sig
    logic [63:0] sig;
  } f2h_cls_t;

endpackage
`default_nettype wire

FILE: rtl/core/f2h_front.sv
`default_nettype none
module f2h_front
  import f2h_pkg::*;
(
  input  wire f2h_in_t  in_i,
  output f2h_cls_t      cls_o
);
  logic        dbl;
  logic [10:0] expf;
  logic [51:0] frac;
  logic        emax;
  logic [63:0] m;
  logic [12:0] e0;

  always_comb begin
    dbl = in_i.command;
    if (dbl) begin
      expf = in_i.source_bits[62:52];
      frac = in_i.source_bits[51:0];
      emax = &in_i.source_bits[62:52];
      cls_o.sign = in_i.source_bits[63];
      cls_o.snan = ~in_i.source_bits[51];
      m = {11'd0, expf != 11'd0, frac};
      // bit 63 weight: max(e,1) - 1023 - 52 + 63
      e0 = 13'(expf == 11'd0 ? 1 : expf) - 13'd1012;
    end else begin
      expf = {3'd0, in_i.source_bits[30:23]};
      frac = {29'd0, in_i.source_bits[22:0]};
      emax = &in_i.source_bits[30:23];
      cls_o.sign = in_i.source_bits[31];
      cls_o.snan = ~in_i.source_bits[22];
      m = {40'd0, expf != 11'd0, frac[22:0]};
      e0 = 13'(expf == 11'd0 ? 1 : expf) - 13'd87;
    end
    if (emax) cls_o.cls = (frac != 52'd0) ? CL_NAN : CL_INF;
    else if (expf == 11'd0 && frac == 52'd0) cls_o.cls = CL_ZERO;
    else cls_o.cls = CL_FIN;
    cls_o.rm = (in_i.rounding_mode > 3'd4) ? RM_RNE : f2h_rm_e'(in_i.rounding_mode);
    cls_o.exp_b = e0;
    cls_o.sig = m;
  end
endmodule
`default_nettype wire

FILE: rtl/core/f2h_queue.sv
`default_nettype none
module f2h_queue
  import f2h_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  wire f2h_cls_t data_i,
  output logic          full_o,
  input  wire           pop_i,
  output logic          empty_o,
  output f2h_cls_t      data_o
);
  f2h_cls_t  mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/f2h_back.sv
`default_nettype none
module f2h_back
  import f2h_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           valid_i,
  input  wire f2h_cls_t cls_i,
  output logic          ready_o,
  output logic          empty_o,
  input  wire           pop_i,
  output f2h_out_t      out_o
);
  // Stage A: normalize. Stage B: round and pack into the output register.
  logic        a_vld_q;
  f2h_cls_t    a_q;
  f2h_cls_t    a_d;
  logic        o_vld_q;
  f2h_out_t    o_q;
  logic        a_adv, o_adv;

  logic [5:0]  lz;
  logic [63:0] norm;

  assign o_adv   = !o_vld_q || (pop_i && o_vld_q);
  assign a_adv   = !a_vld_q || o_adv;
  assign ready_o = a_adv;
  assign empty_o = !o_vld_q;
  assign out_o   = o_q;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (cls_i.sig[i]) lz = 6'(63 - i);
    end
    norm = cls_i.sig << lz;
    a_d = cls_i;
    a_d.sig = norm;
    a_d.exp_b = cls_i.exp_b - 13'(lz);
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && valid_i) a_q <= a_d;
  end

  function automatic logic rinc(f2h_rm_e rm, logic sign, logic lsb, logic rb, logic st);
    case (rm)
      RM_RTZ:  return 1'b0;
      RM_RDN:  return (rb | st) & sign;
      RM_RUP:  return (rb | st) & ~sign;
      RM_RMM:  return rb;
      default: return rb & (st | lsb);
    endcase
  endfunction

  function automatic logic [15:0] ovf(f2h_rm_e rm, logic sign);
    case (rm)
      RM_RTZ:  return {sign, 15'h7BFF};
      RM_RDN:  return sign ? 16'hFC00 : 16'h7BFF;
      RM_RUP:  return sign ? 16'hFBFF : 16'h7C00;
      default: return {sign, 15'h7C00};
    endcase
  endfunction

  // e is exponent of leading one; sig[63] is the leading one.
  logic signed [12:0] e;
  logic [11:0] kn;
  logic        ln;
  logic [6:0]  sh;
  logic [63:0] dm;
  logic [11:0] ks;
  logic        rbs, sts, ls;
  logic [15:0] res;
  logic [4:0]  flg;

  always_comb begin
    e   = signed'(a_q.exp_b);
    kn  = {1'b0, a_q.sig[63:53]} +
          12'(rinc(a_q.rm, a_q.sign, a_q.sig[53], a_q.sig[52], |a_q.sig[51:0]));
    ln  = |a_q.sig[52:0];
    // subnormal: shift further by (-14 - e), capped
    sh  = (e < -13'sd80) ? 7'd80 : 7'(-13'sd14 - e);
    dm  = (sh >= 7'd64) ? 64'd0 : (a_q.sig >> sh);
    ks  = {1'b0, dm[63:53]};
    rbs = (sh >= 7'd64) ? 1'b0 : dm[52];
    sts = (sh >= 7'd64) ? |a_q.sig
                        : (|dm[51:0] || ((a_q.sig << (7'd64 - sh)) != 64'd0));
    ls  = rbs | sts;
    ks  = ks + 12'(rinc(a_q.rm, a_q.sign, dm[53], rbs, sts));
    res = 16'd0;
    flg = 5'd0;
    unique case (a_q.cls)
      CL_NAN:  begin res = 16'h7E00; flg = a_q.snan ? FLAG_NV : 5'd0; end
      CL_INF:  res = {a_q.sign, 15'h7C00};
      CL_ZERO: res = {a_q.sign, 15'd0};
      default: begin
        if (e >= 13'sd16 || (e == 13'sd15 && kn == 12'd2048)) begin
          res = ovf(a_q.rm, a_q.sign);
          flg = FLAG_OF | FLAG_NX;
        end else if (e >= -13'sd14) begin
          res = (kn == 12'd2048) ? {a_q.sign, 5'(e + 13'sd16), 10'd0}
                                 : {a_q.sign, 5'(e + 13'sd15), kn[9:0]};
          flg = ln ? FLAG_NX : 5'd0;
        end else begin
          res = {a_q.sign, 4'd0, ks[10:0]};
          if (ls) flg = FLAG_NX |
                        (((e < -13'sd15) || kn != 12'd2048) ? FLAG_UF : 5'd0);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (o_adv && a_vld_q) o_q <= '{half_bits: res, exception_flags: flg};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0; o_vld_q <= 1'b0;
    end else begin
      if (a_adv) a_vld_q <= valid_i;
      if (o_adv) o_vld_q <= a_vld_q;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/float_to_half_convert_unit.sv
`default_nettype none
// Binary32/binary64 to binary16 converter.
// Input channel: drive push with a word on in_i (command, source_bits,
// rounding_mode); the word is taken at a clock edge where push is high
// and full is low.
// Result channel: while empty is low, out_o holds the oldest result
// (half_bits, exception_flags); assert pop to take it.
// The front decodes and classifies each word in the accept cycle and
// writes it to a two-entry queue. The back normalizes in one stage and
// rounds and packs into the output register in a second.
// A pushed word is registered in the queue, then in the normalize stage,
// then in the output register. Throughput: one word per cycle when pop keeps up.
// If the receiver stalls, the back pipeline holds, the queue fills and
// full rises after at most four words are in flight; no word is lost.
// Reset (rst_ni low, asynchronous) empties the queue and the pipeline;
// full is low and empty high right after.
module float_to_half_convert_unit
  import f2h_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push,
  output logic          full,
  input  wire f2h_in_t  in_i,
  output logic          empty,
  input  wire           pop,
  output f2h_out_t      out_o
);
  f2h_cls_t cls_d, cls_q;
  logic     q_empty, b_ready;

  f2h_front u_front (.in_i(in_i), .cls_o(cls_d));

  f2h_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(push), .data_i(cls_d), .full_o(full),
    .pop_i(b_ready), .empty_o(q_empty), .data_o(cls_q)
  );

  f2h_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .valid_i(!q_empty), .cls_i(cls_q), .ready_o(b_ready),
    .empty_o(empty), .pop_i(pop), .out_o(out_o)
  );
endmodule
`default_nettype wire

FILE: rtl/core/f2h_checker.sv
`default_nettype none
module f2h_checker
  import f2h_pkg::*;
(
  input wire           clk_i,
  input wire           rst_ni,
  input wire           full,
  input wire           empty,
  input wire           pop,
  input wire f2h_out_t out_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o))) else $error("result dropped");
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !out_o.exception_flags[3]) else $error("dz flag set");
  a_uf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.exception_flags[1]) |-> out_o.exception_flags[0])
    else $error("underflow without inexact");
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.exception_flags[4]) |-> (out_o.half_bits == 16'h7E00))
    else $error("invalid without nan");
  // A full queue means the back is stalled on a waiting result.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty) else $error("full without result");
endmodule

bind float_to_half_convert_unit f2h_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .full(full),
  .empty(empty), .pop(pop), .out_o(out_o)
);
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import f2h_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  f2h_in_t  in_i = '0;
  logic     full;
  logic     empty;
  f2h_out_t out_o;

  localparam int STALL_LIMIT = 20000;

  f2h_out_t half_q[$];
  int       fail_cnt = 0;
  int       idle_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_pop = 1'b0;

  always #4 clk_i = ~clk_i;

  float_to_half_convert_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  // Shift right by amt, round per mode; lost flags any discarded bit.
  function automatic logic [63:0] shift_round(input logic [63:0] m, input int amt,
                                              input f2h_rm_e rm, input logic sign,
                                              output logic lost);
    logic [63:0] kept;
    logic        rb;
    logic        st;
    logic        inc;
    if (amt == 0) begin
      kept = m; rb = 1'b0; st = 1'b0;
    end else if (amt >= 64) begin
      kept = 64'd0;
      rb = (amt == 64) ? m[63] : 1'b0;
      st = (amt == 64) ? (m[62:0] != 0) : (m != 0);
    end else begin
      kept = m >> amt;
      rb = m[amt-1];
      st = (m & ((64'd1 << (amt - 1)) - 64'd1)) != 0;
    end
    case (rm)
      RM_RTZ: inc = 1'b0;
      RM_RDN: inc = (rb | st) & sign;
      RM_RUP: inc = (rb | st) & ~sign;
      RM_RMM: inc = rb;
      default: inc = rb & (st | kept[0]);
    endcase
    lost = rb | st;
    return kept + 64'(inc);
  endfunction

  function automatic logic [15:0] saturate_half(input f2h_rm_e rm, input logic sign);
    case (rm)
      RM_RTZ: return {sign, 15'h7BFF};
      RM_RDN: return sign ? 16'hFC00 : 16'h7BFF;
      RM_RUP: return sign ? 16'hFBFF : 16'h7C00;
      default: return {sign, 15'h7C00};
    endcase
  endfunction

  function automatic f2h_out_t convert_half(input f2h_in_t w);
    f2h_out_t    r;
    f2h_rm_e     rm;
    logic [63:0] bits;
    logic [63:0] frac;
    logic [63:0] m;
    logic [63:0] kept;
    int          fbits;
    int          expmax;
    int          bias;
    int          expf;
    int          e;
    logic        sign;
    logic        lost;
    logic        lost2;
    logic        tiny;
    r = '0;
    rm = (w.rounding_mode > 3'd4) ? RM_RNE : f2h_rm_e'(w.rounding_mode);
    bits = w.command ? w.source_bits : {32'd0, w.source_bits[31:0]};
    fbits = w.command ? 52 : 23;
    expmax = w.command ? 'h7FF : 'hFF;
    bias = w.command ? 1023 : 127;
    sign = w.command ? bits[63] : bits[31];
    expf = int'((bits >> fbits) & 64'(expmax));
    frac = bits & ((64'd1 << fbits) - 64'd1);
    if (expf == expmax) begin
      if (frac != 0) begin
        r.half_bits = 16'h7E00;
        if (!frac[fbits-1]) r.exception_flags = FLAG_NV;
      end else begin
        r.half_bits = {sign, 15'h7C00};
      end
    end else if (expf == 0 && frac == 0) begin
      r.half_bits = {sign, 15'd0};
    end else begin
      m = frac | ((expf != 0) ? (64'd1 << fbits) : 64'd0);
      e = ((expf != 0) ? expf : 1) - bias - fbits + 62;
      while (!m[62]) begin
        m = m << 1;
        e--;
      end
      if (e >= 16) begin
        r.half_bits = saturate_half(rm, sign);
        r.exception_flags = FLAG_OF | FLAG_NX;
      end else if (e >= -14) begin
        kept = shift_round(m, 52, rm, sign, lost);
        if (kept == 2048) begin
          kept = 64'd1024;
          e++;
        end
        if (e >= 16) begin
          r.half_bits = saturate_half(rm, sign);
          r.exception_flags = FLAG_OF | FLAG_NX;
        end else begin
          r.half_bits = {sign, 5'(e + 15), kept[9:0]};
          r.exception_flags = lost ? FLAG_NX : 5'd0;
        end
      end else begin
        kept = shift_round(m, 52 + (-14 - e), rm, sign, lost);
        r.half_bits = {sign, 4'd0, kept[10:0]};
        if (e < -15) tiny = 1'b1;
        else tiny = shift_round(m, 52, rm, sign, lost2) != 2048;
        if (lost) r.exception_flags = FLAG_NX | (tiny ? FLAG_UF : 5'd0);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_cnt++;
  endtask

  // Drive one word; hold push until accepted, then drop it unless the next word follows.
  task automatic send_word(input f2h_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    half_q.push_back(convert_half(w));
  endtask

  // Pick the pop for the next edge; a long hold-off overrides.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= !hold_pop && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each popped word against the oldest expectation.
  always @(posedge clk_i) begin
    f2h_out_t want;
    if (rst_ni && pop && !empty) begin
      if (half_q.size() == 0) begin
        report_mismatch("unexpected word", out_o.half_bits, 16'd0);
      end else begin
        want = half_q.pop_front();
        if (out_o.half_bits !== want.half_bits)
          report_mismatch("half_bits", out_o.half_bits, want.half_bits);
        if (out_o.exception_flags !== want.exception_flags)
          report_mismatch("flags", 16'(out_o.exception_flags), 16'(want.exception_flags));
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic f2h_in_t make_word(input logic cmd, input logic [63:0] b,
                                        input logic [2:0] rm);
    f2h_in_t w;
    w.command = cmd;
    w.source_bits = b;
    w.rounding_mode = rm;
    return w;
  endfunction

  // Random value biased toward the half range, the rounding boundaries and specials.
  function automatic f2h_in_t rand_word();
    logic        cmd;
    logic [63:0] b;
    int          ex;
    cmd = 1'($urandom_range(1));
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0: ;
      1, 2, 3: begin
        ex = $urandom_range(50) - 30;
        if (cmd) b[62:52] = 11'(1023 + ex);
        else b[30:23] = 8'(127 + ex);
        if ($urandom_range(1)) begin
          if (cmd) b[40:0] = $urandom_range(1) ? 41'h0 : 41'h1FFFFFFFFFF;
          else b[12:0] = $urandom_range(1) ? 13'h0 : 13'h1FFF;
        end
      end
      default: begin
        if (cmd) b[62:52] = $urandom_range(1) ? 11'h7FF : 11'h0;
        else b[30:23] = $urandom_range(1) ? 8'hFF : 8'h0;
      end
    endcase
    return make_word(cmd, b, 3'($urandom_range(7)));
  endfunction

  task automatic drain();
    push <= 1'b0;
    while (half_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [63:0] v[$];
    v = {64'h0, 64'h80000000, 64'h7F800000, 64'hFF800000, 64'h7FC00000,
         64'h7F800001, 64'h477FE000, 64'h477FF000, 64'h47800000, 64'h33800000,
         64'h33000000, 64'h00000001, 64'h387FE000, 64'h3F800001, 64'hFFFFFFFF3F800000};
    foreach (v[k]) send_word(make_word(1'b0, v[k], 3'(k % 8)));
    for (int r = 0; r < 8; r++) begin
      send_word(make_word(1'b0, 64'hC7FFFFFF, 3'(r)));
      send_word(make_word(1'b1, 64'h3E70000000000001, 3'(r)));
    end
    send_word(make_word(1'b1, 64'h7FF0000000000001, RM_RNE));
    send_word(make_word(1'b1, 64'hFFF8000000000000, RM_RTZ));
    send_word(make_word(1'b1, 64'h0000000000000001, RM_RUP));
    send_word(make_word(1'b1, 64'hFFFFFFFFFFFFFFFF, RM_RDN));
    drain();
  endtask

  task automatic test_random(input int n, input int sidle, input int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) send_word(rand_word());
    drain();
  endtask

  // Hold pop off long enough that the queue fills and full rises.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_pop = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_pop = 1'b0;
      end
      repeat (40) send_word(rand_word());
    join
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(350, 0, 0);
    test_random(350, 69, 0);
    test_random(350, 0, 69);
    test_random(350, 24, 24);
    test_backpressure();
    if (fail_cnt == 0 && half_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
